### rtl/gts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gts_pkg;

  localparam int RATE_W     = 48;
  localparam int HALF_W     = 16;
  localparam int CFG_W      = 48;
  localparam int CFG_IDX_W  = 4;
  localparam int RAND_W     = 32;
  localparam int TIME_W     = 63;
  localparam int OUT_CNT_W  = 16;
  localparam int LOG_FRAC   = 30;
  localparam int NL2_W      = 36;
  localparam int TAU_SHIFT  = 26;
  localparam int DIV_CNT_W  = 7;
  localparam int HILL_ITERS = 32;
  localparam int TAU_ITERS  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_K_BASAL  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_MAX    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K_HALF   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_M_BASAL  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_M_MAX    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_M_HALF   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLED  = 4'd7;

  localparam logic [RATE_W-1:0] K_BASAL_RESET = 48'd0;
  localparam logic [RATE_W-1:0] K_MAX_RESET   = 48'd32212254720;
  localparam logic [HALF_W-1:0] K_HALF_RESET  = 16'd5000;
  localparam logic [RATE_W-1:0] M_BASAL_RESET = 48'd322122547;
  localparam logic [RATE_W-1:0] M_MAX_RESET   = 48'd10737418240;
  localparam logic [HALF_W-1:0] M_HALF_RESET  = 16'd2500;
  localparam logic [RATE_W-1:0] DECAY_RESET   = 48'd28147497671;
  localparam logic [RATE_W-1:0] COUPLED_RESET = 48'd11258999;
  localparam int COUNT_K_RESET = 500;
  localparam int COUNT_M_RESET = 150;

  localparam logic [63:0] PCAP = 64'h0FFF_FFFF_FFFF_FFFF;
  localparam logic [TIME_W-1:0] TIME_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  localparam logic [1:0] RX_K_MADE = 2'd0;
  localparam logic [1:0] RX_K_GONE = 2'd1;
  localparam logic [1:0] RX_M_MADE = 2'd2;
  localparam logic [1:0] RX_M_GONE = 2'd3;

  typedef struct packed {
    logic [RAND_W-1:0] rand_time;
    logic [RAND_W-1:0] rand_pick;
  } in_word_t;

  typedef struct packed {
    logic                 status;
    logic [1:0]           reaction;
    logic [OUT_CNT_W-1:0] count_k_out;
    logic [OUT_CNT_W-1:0] count_m_out;
    logic [TIME_W-1:0]    step_time;
    logic [TIME_W-1:0]    time_now;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_KK,
    OP_HILL_K,
    OP_RATE_K,
    OP_HILL_M,
    OP_RATE_M,
    OP_MUL_CM,
    OP_MUL_SK,
    OP_MUL_DM,
    OP_SUM,
    OP_LOG,
    OP_MUL_LN,
    OP_DIV_TAU,
    OP_MUL_PICK,
    OP_UPDATE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic latch;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic ok;
    logic out_free;
  } stat_t;

  function automatic op_t next_op(op_t op);
    unique case (op)
      OP_MUL_KK:   next_op = OP_HILL_K;
      OP_HILL_K:   next_op = OP_RATE_K;
      OP_RATE_K:   next_op = OP_HILL_M;
      OP_HILL_M:   next_op = OP_RATE_M;
      OP_RATE_M:   next_op = OP_MUL_CM;
      OP_MUL_CM:   next_op = OP_MUL_SK;
      OP_MUL_SK:   next_op = OP_MUL_DM;
      OP_MUL_DM:   next_op = OP_SUM;
      OP_SUM:      next_op = OP_LOG;
      OP_LOG:      next_op = OP_MUL_LN;
      OP_MUL_LN:   next_op = OP_DIV_TAU;
      OP_DIV_TAU:  next_op = OP_MUL_PICK;
      OP_MUL_PICK: next_op = OP_UPDATE;
      default:     next_op = OP_NONE;
    endcase
  endfunction

  // floor(p / 2^sh), all ones when it does not fit 64 bits
  function automatic logic [63:0] sat_shr(logic [127:0] p, logic [6:0] sh);
    logic [127:0] q;
    q = p >> sh;
    sat_shr = (q[127:64] != 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  function automatic logic [63:0] cap60(logic [63:0] x);
    cap60 = (x > PCAP) ? PCAP : x;
  endfunction

  function automatic logic [63:0] add_cap(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = 65'(cap60(a)) + 65'(cap60(b));
    add_cap = cap60(s[63:0]);
  endfunction

endpackage
`default_nettype wire

### rtl/gts_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module gts_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         busy,
  output logic         done
);

  logic         running;
  logic [2:0]   idx;
  logic [63:0]  a_q;
  logic [63:0]  b_q;
  logic [63:0]  pp;
  logic [1:0]   pp_sel;
  logic [127:0] acc;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  logic [127:0] pp_ext;

  // partial products: lo*lo, hi*lo, lo*hi, hi*hi
  always_comb begin
    unique case (idx[1:0])
      2'd0: begin
        op_a = a_q[31:0];
        op_b = b_q[31:0];
      end
      2'd1: begin
        op_a = a_q[63:32];
        op_b = b_q[31:0];
      end
      2'd2: begin
        op_a = a_q[31:0];
        op_b = b_q[63:32];
      end
      default: begin
        op_a = a_q[63:32];
        op_b = b_q[63:32];
      end
    endcase
  end

  always_comb begin
    unique case (pp_sel)
      2'd0:    pp_ext = {64'd0, pp};
      2'd1:    pp_ext = {32'd0, pp, 32'd0};
      2'd2:    pp_ext = {32'd0, pp, 32'd0};
      default: pp_ext = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      idx     <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        idx     <= 3'd0;
      end else if (running) begin
        idx <= idx + 3'd1;
        if (idx == 3'd4) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
      acc <= 128'd0;
    end else if (running) begin
      if (idx != 3'd4) begin
        pp     <= op_a * op_b;
        pp_sel <= idx[1:0];
      end
      if (idx != 3'd0) begin
        acc <= acc + pp_ext;
      end
    end
  end

  assign prod = acc;
  assign busy = running | done;

endmodule
`default_nettype wire

### rtl/gts_div.sv
`timescale 1ns / 1ps
`default_nettype none
module gts_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [63:0]                    rem_init,
  input  logic [63:0]                    num,
  input  logic [63:0]                    den,
  input  logic [gts_pkg::DIV_CNT_W-1:0]  iters,
  output logic [63:0]                    quo,
  output logic                           busy,
  output logic                           done
);

  logic                          running;
  logic [gts_pkg::DIV_CNT_W-1:0] cnt;
  logic [63:0]                   rem;
  logic [63:0]                   num_q;
  logic [63:0]                   den_q;
  logic [64:0]                   trial;
  logic [64:0]                   diff;
  logic                          ge;

  assign trial = {rem, num_q[63]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= iters;
      end else if (running) begin
        cnt <= cnt - gts_pkg::DIV_CNT_W'(1);
        if (cnt == gts_pkg::DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      num_q <= num;
      den_q <= den;
      quo   <= 64'd0;
    end else if (running) begin
      rem   <= ge ? diff[63:0] : trial[63:0];
      num_q <= {num_q[62:0], 1'b0};
      quo   <= {quo[62:0], ge};
    end
  end

  assign busy = running | done;

endmodule
`default_nettype wire

### rtl/gts_log.sv
`timescale 1ns / 1ps
`default_nettype none
module gts_log (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                x,
  output logic [gts_pkg::NL2_W-1:0]  nl2,
  output logic                       busy,
  output logic                       done
);

  logic                         running;
  logic                         squaring;
  logic [4:0]                   cnt;
  logic [31:0]                  m;
  logic [4:0]                   z;
  logic [gts_pkg::LOG_FRAC-1:0] frac;
  logic [63:0]                  p;

  assign p = m * m;

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      squaring <= 1'b0;
      done     <= 1'b0;
      cnt      <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        squaring <= 1'b0;
      end else if (running && !squaring) begin
        if (m[31]) begin
          squaring <= 1'b1;
          cnt      <= 5'(gts_pkg::LOG_FRAC);
        end
      end else if (running) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          running  <= 1'b0;
          squaring <= 1'b0;
          done     <= 1'b1;
        end
      end
    end
  end

  // normalize one bit a cycle, then one squaring a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      m    <= x;
      z    <= 5'd0;
      frac <= '0;
    end else if (running && !squaring) begin
      if (!m[31]) begin
        m <= {m[30:0], 1'b0};
        z <= z + 5'd1;
      end
    end else if (running) begin
      m    <= p[63] ? p[63:32] : p[62:31];
      frac <= {frac[gts_pkg::LOG_FRAC-2:0], p[63]};
    end
  end

  assign nl2 = ((gts_pkg::NL2_W'(z) + gts_pkg::NL2_W'(1)) << gts_pkg::LOG_FRAC)
               - gts_pkg::NL2_W'(frac);
  assign busy = running | done;

endmodule
`default_nettype wire

### rtl/gts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  gts_pkg::stat_t  stat,
  output gts_pkg::cmd_t   cmd
);

  gts_pkg::state_t state;
  gts_pkg::state_t state_next;
  gts_pkg::op_t    cur_op;
  gts_pkg::op_t    cur_op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= gts_pkg::S_IDLE;
      cur_op <= gts_pkg::OP_NONE;
    end else begin
      state  <= state_next;
      cur_op <= cur_op_next;
    end
  end

  always_comb begin
    state_next  = state;
    cur_op_next = cur_op;
    cmd.op      = gts_pkg::OP_NONE;
    cmd.latch   = 1'b0;
    req_stall   = 1'b1;
    unique case (state)
      gts_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.latch   = 1'b1;
          cur_op_next = gts_pkg::OP_MUL_KK;
          state_next  = gts_pkg::S_ISSUE;
        end
      end
      gts_pkg::S_ISSUE: begin
        if (cur_op != gts_pkg::OP_UPDATE || stat.out_free) begin
          cmd.op     = cur_op;
          state_next = gts_pkg::S_WAIT;
        end
      end
      gts_pkg::S_WAIT: begin
        if (!stat.busy) begin
          priority if (cur_op == gts_pkg::OP_UPDATE) begin
            state_next = gts_pkg::S_IDLE;
          end else if (cur_op == gts_pkg::OP_SUM && !stat.ok) begin
            cur_op_next = gts_pkg::OP_UPDATE;
            state_next  = gts_pkg::S_ISSUE;
          end else begin
            cur_op_next = gts_pkg::next_op(cur_op);
            state_next  = gts_pkg::S_ISSUE;
          end
        end
      end
      default: begin
        state_next = gts_pkg::S_IDLE;
      end
    endcase
  end

  a_update_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == gts_pkg::OP_UPDATE) |-> stat.out_free)
    else $error("result written while output slot full");

endmodule
`default_nettype wire

### rtl/gts_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module gts_dp #(
  parameter int COUNT_BITS     = 16,
  parameter int RATE_FRAC_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gts_pkg::CFG_W-1:0]       cfg_data,
  input  gts_pkg::in_word_t               req_word,
  input  gts_pkg::cmd_t                   cmd,
  output gts_pkg::stat_t                  stat,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output gts_pkg::out_word_t              rsp_word
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [gts_pkg::RATE_W-1:0] k_basal, k_max, m_basal, m_max, decay, coupled;
  logic [gts_pkg::HALF_W-1:0] k_half, m_half;
  logic [COUNT_BITS-1:0]      count_k, count_m;
  logic [gts_pkg::TIME_W-1:0] sim_time;
  gts_pkg::op_t               pend;

  logic [31:0] r1, r2;
  logic [63:0] n_kk;
  logic [32:0] fk, fm;
  logic [63:0] a1, a2, a3, a4, s, a0, c2, c3;
  logic        ok;
  logic [gts_pkg::NL2_W-1:0] nl2_q;
  logic [63:0] ln, tau, pick;

  logic         mul_start, mul_busy, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] prod;
  logic         div_start, div_busy, div_done;
  logic [63:0]  div_rem, div_num, div_den, quo;
  logic [gts_pkg::DIV_CNT_W-1:0] div_iters;
  logic         log_start, log_busy, log_done;
  logic [gts_pkg::NL2_W-1:0] nl2;

  logic                       is_hill;
  logic [gts_pkg::HALF_W-1:0] h;
  logic [31:0]                h2;
  logic [64:0]                d65;
  logic [63:0]                hn, hd;
  logic                       hill_zero, hill_full;
  logic [63:0]                kb_term, mb_term;
  logic [63:0]                sum2, sum3, sum4;

  logic [1:0]                 react;
  logic [COUNT_BITS-1:0]      k_new, m_new;
  logic [63:0]                tsum;
  logic [gts_pkg::TIME_W-1:0] t_new;
  logic [31:0]                k_ext, m_ext, k_now, m_now;

  gts_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .busy  (mul_busy),
    .done  (mul_done)
  );

  gts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .num      (div_num),
    .den      (div_den),
    .iters    (div_iters),
    .quo      (quo),
    .busy     (div_busy),
    .done     (div_done)
  );

  gts_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .x     (r1),
    .nl2   (nl2),
    .busy  (log_busy),
    .done  (log_done)
  );

  // multiplier operands
  always_comb begin
    mul_start = 1'b1;
    unique case (cmd.op)
      gts_pkg::OP_MUL_KK: begin
        mul_a = 64'(count_k);
        mul_b = 64'(count_k);
      end
      gts_pkg::OP_RATE_K: begin
        mul_a = 64'(k_max);
        mul_b = 64'(fk);
      end
      gts_pkg::OP_RATE_M: begin
        mul_a = 64'(m_max);
        mul_b = 64'(fm);
      end
      gts_pkg::OP_MUL_CM: begin
        mul_a = 64'(coupled);
        mul_b = 64'(count_m);
      end
      gts_pkg::OP_MUL_SK: begin
        mul_a = s;
        mul_b = 64'(count_k);
      end
      gts_pkg::OP_MUL_DM: begin
        mul_a = 64'(decay);
        mul_b = 64'(count_m);
      end
      gts_pkg::OP_MUL_LN: begin
        mul_a = 64'(nl2_q);
        mul_b = 64'(gts_pkg::LN2_Q32);
      end
      gts_pkg::OP_MUL_PICK: begin
        mul_a = 64'(r2);
        mul_b = a0;
      end
      default: begin
        mul_start = 1'b0;
        mul_a     = 64'd0;
        mul_b     = 64'd0;
      end
    endcase
  end

  // hill setup: square sum halved when it passes 64 bits
  assign is_hill = (cmd.op == gts_pkg::OP_HILL_K) || (cmd.op == gts_pkg::OP_HILL_M);
  assign h       = (cmd.op == gts_pkg::OP_HILL_M) ? m_half : k_half;
  assign h2      = h * h;
  assign d65     = {1'b0, n_kk} + 65'(h2);

  always_comb begin
    if (d65[64]) begin
      hn = {1'b0, n_kk[63:1]};
      hd = hn + 64'(h2[31:1]);
    end else begin
      hn = n_kk;
      hd = d65[63:0];
    end
  end

  assign hill_zero = (hd == 64'd0);
  assign hill_full = (hn >= hd);

  always_comb begin
    div_start = 1'b0;
    div_rem   = hn;
    div_num   = 64'd0;
    div_den   = hd;
    div_iters = gts_pkg::DIV_CNT_W'(gts_pkg::HILL_ITERS);
    if (is_hill) begin
      div_start = !hill_zero && !hill_full;
    end else if (cmd.op == gts_pkg::OP_DIV_TAU) begin
      div_start = 1'b1;
      div_rem   = 64'd0;
      div_num   = ln << gts_pkg::TAU_SHIFT;
      div_den   = a0;
      div_iters = gts_pkg::DIV_CNT_W'(gts_pkg::TAU_ITERS);
    end
  end

  assign log_start = (cmd.op == gts_pkg::OP_LOG);

  assign kb_term = 64'({k_basal, 32'd0} >> RATE_FRAC_BITS);
  assign mb_term = 64'({m_basal, 32'd0} >> RATE_FRAC_BITS);

  assign sum2 = a1 + a2;
  assign sum3 = sum2 + a3;
  assign sum4 = sum3 + a4;

  // reaction pick and state update
  always_comb begin
    priority if (pick < a1) begin
      react = gts_pkg::RX_K_MADE;
    end else if (pick < c2) begin
      react = gts_pkg::RX_K_GONE;
    end else if (pick < c3) begin
      react = gts_pkg::RX_M_MADE;
    end else begin
      react = gts_pkg::RX_M_GONE;
    end
  end

  always_comb begin
    k_new = count_k;
    m_new = count_m;
    unique case (react)
      gts_pkg::RX_K_MADE: if (count_k != CNT_MAX) k_new = count_k + COUNT_BITS'(1);
      gts_pkg::RX_K_GONE: if (count_k != '0) k_new = count_k - COUNT_BITS'(1);
      gts_pkg::RX_M_MADE: if (count_m != CNT_MAX) m_new = count_m + COUNT_BITS'(1);
      default:            if (count_m != '0) m_new = count_m - COUNT_BITS'(1);
    endcase
  end

  assign tsum  = 64'(sim_time) + tau;
  assign t_new = (tsum > 64'(gts_pkg::TIME_MAX)) ? gts_pkg::TIME_MAX : tsum[62:0];
  assign k_ext = 32'(k_new);
  assign m_ext = 32'(m_new);
  assign k_now = 32'(count_k);
  assign m_now = 32'(count_m);

  // configuration and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      k_basal   <= gts_pkg::K_BASAL_RESET;
      k_max     <= gts_pkg::K_MAX_RESET;
      k_half    <= gts_pkg::K_HALF_RESET;
      m_basal   <= gts_pkg::M_BASAL_RESET;
      m_max     <= gts_pkg::M_MAX_RESET;
      m_half    <= gts_pkg::M_HALF_RESET;
      decay     <= gts_pkg::DECAY_RESET;
      coupled   <= gts_pkg::COUPLED_RESET;
      count_k   <= COUNT_BITS'(gts_pkg::COUNT_K_RESET);
      count_m   <= COUNT_BITS'(gts_pkg::COUNT_M_RESET);
      sim_time  <= '0;
      rsp_valid <= 1'b0;
      pend      <= gts_pkg::OP_NONE;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          gts_pkg::CFG_K_BASAL: k_basal <= cfg_data;
          gts_pkg::CFG_K_MAX:   k_max   <= cfg_data;
          gts_pkg::CFG_K_HALF:  k_half  <= cfg_data[gts_pkg::HALF_W-1:0];
          gts_pkg::CFG_M_BASAL: m_basal <= cfg_data;
          gts_pkg::CFG_M_MAX:   m_max   <= cfg_data;
          gts_pkg::CFG_M_HALF:  m_half  <= cfg_data[gts_pkg::HALF_W-1:0];
          gts_pkg::CFG_DECAY:   decay   <= cfg_data;
          gts_pkg::CFG_COUPLED: coupled <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op != gts_pkg::OP_NONE) begin
        pend <= cmd.op;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.op == gts_pkg::OP_UPDATE) begin
        rsp_valid <= 1'b1;
        if (ok) begin
          count_k  <= k_new;
          count_m  <= m_new;
          sim_time <= t_new;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r1 <= req_word.rand_time;
      r2 <= req_word.rand_pick;
    end
    if (is_hill && (hill_zero || hill_full)) begin
      if (cmd.op == gts_pkg::OP_HILL_K) begin
        fk <= hill_zero ? 33'd0 : {1'b1, 32'd0};
      end else begin
        fm <= hill_zero ? 33'd0 : {1'b1, 32'd0};
      end
    end
    if (cmd.op == gts_pkg::OP_SUM) begin
      c2 <= sum2;
      c3 <= sum3;
      a0 <= sum4;
      ok <= (r1 != 32'd0) && (r2 != 32'd0) && (sum4 != 64'd0);
    end
    if (mul_done) begin
      unique case (pend)
        gts_pkg::OP_MUL_KK:   n_kk <= prod[63:0];
        gts_pkg::OP_RATE_K:
          a1 <= gts_pkg::add_cap(kb_term, gts_pkg::sat_shr(prod, 7'(RATE_FRAC_BITS)));
        gts_pkg::OP_RATE_M:
          a3 <= gts_pkg::add_cap(mb_term, gts_pkg::sat_shr(prod, 7'(RATE_FRAC_BITS)));
        gts_pkg::OP_MUL_CM:
          s <= gts_pkg::add_cap(gts_pkg::sat_shr(prod, 7'd0), 64'(decay));
        gts_pkg::OP_MUL_SK:   a2 <= gts_pkg::cap60(gts_pkg::sat_shr(prod, 7'd16));
        gts_pkg::OP_MUL_DM:   a4 <= gts_pkg::cap60(gts_pkg::sat_shr(prod, 7'd16));
        gts_pkg::OP_MUL_LN:   ln <= gts_pkg::sat_shr(prod, 7'd32);
        gts_pkg::OP_MUL_PICK: pick <= gts_pkg::sat_shr(prod, 7'd32);
        default: ;
      endcase
    end
    if (div_done) begin
      unique case (pend)
        gts_pkg::OP_HILL_K:  fk <= {1'b0, quo[31:0]};
        gts_pkg::OP_HILL_M:  fm <= {1'b0, quo[31:0]};
        gts_pkg::OP_DIV_TAU: tau <= quo;
        default: ;
      endcase
    end
    if (log_done) begin
      nl2_q <= nl2;
    end
    if (cmd.op == gts_pkg::OP_UPDATE) begin
      if (ok) begin
        rsp_word.status      <= 1'b0;
        rsp_word.reaction    <= react;
        rsp_word.count_k_out <= k_ext[gts_pkg::OUT_CNT_W-1:0];
        rsp_word.count_m_out <= m_ext[gts_pkg::OUT_CNT_W-1:0];
        rsp_word.step_time   <= tau[62:0];
        rsp_word.time_now    <= t_new;
      end else begin
        rsp_word.status      <= 1'b1;
        rsp_word.reaction    <= gts_pkg::RX_K_MADE;
        rsp_word.count_k_out <= k_now[gts_pkg::OUT_CNT_W-1:0];
        rsp_word.count_m_out <= m_now[gts_pkg::OUT_CNT_W-1:0];
        rsp_word.step_time   <= '0;
        rsp_word.time_now    <= sim_time;
      end
    end
  end

  assign stat.busy     = mul_busy | div_busy | log_busy;
  assign stat.ok       = ok;
  assign stat.out_free = !rsp_valid || !rsp_stall;

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_busy, div_busy, log_busy}))
    else $error("two arithmetic units busy at once");

  a_word_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.op == gts_pkg::OP_UPDATE))
    else $error("result word raised without an update");

endmodule
`default_nettype wire

### rtl/gillespie_two_species_step.sv
`timescale 1ns / 1ps
`default_nettype none
// one word in, one word out; the time from accept to result depends on log normalization
// (shorter when both hill fractions are trivial or the step is rejected)
// the time is set by eight passes of the multiplier, the one-bit-a-cycle divider (two
// 32-bit hill quotients, one 64-bit waiting time) and the log unit
// no word is taken before the last result is written; the next is taken while that result waits
// rst (synchronous) loads the default rates, K 500, M 150 and time zero
module gillespie_two_species_step #(
  parameter int COUNT_BITS     = 16,
  parameter int RATE_FRAC_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  gts_pkg::in_word_t             req_word,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output gts_pkg::out_word_t            rsp_word,
  input  logic                          cfg_write,
  input  logic [gts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gts_pkg::CFG_W-1:0]     cfg_data
);

  gts_pkg::cmd_t  cmd;
  gts_pkg::stat_t stat;

  gts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  gts_dp #(
    .COUNT_BITS     (COUNT_BITS),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_word  (req_word),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

endmodule
`default_nettype wire

### bench/gillespie_two_species_step_test.sv
`timescale 1ns / 1ps
module gillespie_two_species_step_test;

  localparam logic [gts_pkg::CFG_IDX_W-1:0] CFG_SPARE = 4'd9;
  localparam logic [63:0] TIME_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] RATE_CAP = 64'h0FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CNT_MAX = 64'd65535;
  localparam logic [47:0] ALL_ONES48 = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  gts_pkg::in_word_t req_word = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  gts_pkg::out_word_t rsp_word;
  logic cfg_write = 1'b0;
  logic [gts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gts_pkg::CFG_W-1:0] cfg_data = '0;

  gillespie_two_species_step dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // model of the kinetics
  logic [63:0] k_basal, k_max, k_half, m_basal, m_max, m_half, decay, coupled;
  logic [63:0] count_k, count_m, sim_clock;

  gts_pkg::in_word_t pending_words[$];
  gts_pkg::out_word_t expected_steps[$];
  int errors = 0;
  int results_seen = 0;
  bit offering = 0;
  bit quiet_tx = 0;
  bit quiet_rx = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  gts_pkg::in_word_t next_word;

  function automatic logic [63:0] scaled_prod(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return (p[127:64] != 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  function automatic logic [63:0] clamp60(logic [63:0] x);
    return (x > RATE_CAP) ? RATE_CAP : x;
  endfunction

  function automatic logic [63:0] sum_clamp(logic [63:0] a, logic [63:0] b);
    return clamp60(clamp60(a) + clamp60(b));
  endfunction

  function automatic logic [63:0] hill_frac(logic [63:0] k, logic [63:0] h);
    logic [63:0] n, d;
    logic [95:0] num, q;
    n = k * k;
    d = n + h * h;
    if (d == 64'd0) return 64'd0;
    if (n >= d) return 64'd1 << 32;
    num = {n[63:0], 32'd0};
    q = num / {32'd0, d};
    return q[63:0];
  endfunction

  function automatic logic [63:0] neg_log(logic [31:0] x);
    int e;
    logic [63:0] m, frac, nl2;
    e = 31;
    frac = 0;
    while (!x[e]) e--;
    m = {32'd0, x} << (31 - e);
    for (int i = 0; i < gts_pkg::LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    nl2 = (64'(32 - e) << gts_pkg::LOG_FRAC) - frac;
    return scaled_prod(nl2, {32'd0, gts_pkg::LN2_Q32}, 32);
  endfunction

  task automatic advance_model(gts_pkg::in_word_t w);
    logic [63:0] one, a1, a2, a3, a4, a0, s, pick, tau;
    logic [1:0] react;
    bit ok;
    gts_pkg::out_word_t r;
    one = 64'd1 << 32;
    tau = 0;
    react = gts_pkg::RX_K_MADE;
    a1 = sum_clamp(scaled_prod(k_basal, one, 32),
                   scaled_prod(k_max, hill_frac(count_k, k_half), 32));
    s = sum_clamp(scaled_prod(coupled, count_m, 0), decay);
    a2 = clamp60(scaled_prod(s, count_k, 16));
    a3 = sum_clamp(scaled_prod(m_basal, one, 32),
                   scaled_prod(m_max, hill_frac(count_k, m_half), 32));
    a4 = clamp60(scaled_prod(decay, count_m, 16));
    a0 = a1 + a2 + a3 + a4;
    ok = (w.rand_time != 0) && (w.rand_pick != 0) && (a0 != 0);
    if (ok) begin
      tau = (neg_log(w.rand_time) << gts_pkg::TAU_SHIFT) / a0;
      pick = scaled_prod({32'd0, w.rand_pick}, a0, 32);
      if (pick < a1) react = gts_pkg::RX_K_MADE;
      else if (pick < a1 + a2) react = gts_pkg::RX_K_GONE;
      else if (pick < a1 + a2 + a3) react = gts_pkg::RX_M_MADE;
      else react = gts_pkg::RX_M_GONE;
      case (react)
        gts_pkg::RX_K_MADE: if (count_k < CNT_MAX) count_k = count_k + 1;
        gts_pkg::RX_K_GONE: if (count_k > 0) count_k = count_k - 1;
        gts_pkg::RX_M_MADE: if (count_m < CNT_MAX) count_m = count_m + 1;
        default:            if (count_m > 0) count_m = count_m - 1;
      endcase
      sim_clock = (TIME_CAP - sim_clock < tau) ? TIME_CAP : sim_clock + tau;
    end
    r.status = !ok;
    r.reaction = react;
    r.count_k_out = count_k[15:0];
    r.count_m_out = count_m[15:0];
    r.step_time = tau[62:0];
    r.time_now = sim_clock[62:0];
    expected_steps.push_back(r);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  task automatic check_step(gts_pkg::out_word_t got);
    gts_pkg::out_word_t want;
    if (expected_steps.size() == 0) begin
      report("unexpected word", 64'(got.status), 64'd0);
      return;
    end
    want = expected_steps.pop_front();
    if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
    if (got.reaction !== want.reaction)
      report("reaction", 64'(got.reaction), 64'(want.reaction));
    if (got.count_k_out !== want.count_k_out)
      report("count_k_out", 64'(got.count_k_out), 64'(want.count_k_out));
    if (got.count_m_out !== want.count_m_out)
      report("count_m_out", 64'(got.count_m_out), 64'(want.count_m_out));
    if (got.step_time !== want.step_time)
      report("step_time", 64'(got.step_time), 64'(want.step_time));
    if (got.time_now !== want.time_now)
      report("time_now", 64'(got.time_now), 64'(want.time_now));
  endtask

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      offering = 0;
      send_gap = 0;
    end else begin
      if (req_valid && !req_stall) begin
        advance_model(req_word);
        offering = 0;
        if ($urandom_range(0, 99) < 3) quiet_tx = !quiet_tx;
        send_gap = draw_gap(quiet_tx);
      end
      if (!offering) begin
        if (send_gap > 0) send_gap--;
        else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          offering = 1;
        end
      end
      req_valid <= offering;
      if (offering) req_word <= next_word;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        check_step(rsp_word);
        results_seen++;
        if ($urandom_range(0, 99) < 3) quiet_rx = !quiet_rx;
        stall_left = draw_gap(quiet_rx);
        if (results_seen == 200) hold_left = 3000;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_left > 0) hold_left--;
      rsp_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  task automatic write_reg(logic [gts_pkg::CFG_IDX_W-1:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      gts_pkg::CFG_K_BASAL: k_basal = 64'(val);
      gts_pkg::CFG_K_MAX:   k_max = 64'(val);
      gts_pkg::CFG_K_HALF:  k_half = 64'(val[15:0]);
      gts_pkg::CFG_M_BASAL: m_basal = 64'(val);
      gts_pkg::CFG_M_MAX:   m_max = 64'(val);
      gts_pkg::CFG_M_HALF:  m_half = 64'(val[15:0]);
      gts_pkg::CFG_DECAY:   decay = 64'(val);
      gts_pkg::CFG_COUPLED: coupled = 64'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(logic [47:0] kb, logic [47:0] km, logic [47:0] kh,
                           logic [47:0] mb, logic [47:0] mm, logic [47:0] mh,
                           logic [47:0] dc, logic [47:0] cp);
    write_reg(gts_pkg::CFG_K_BASAL, kb);
    write_reg(gts_pkg::CFG_K_MAX, km);
    write_reg(gts_pkg::CFG_K_HALF, kh);
    write_reg(gts_pkg::CFG_M_BASAL, mb);
    write_reg(gts_pkg::CFG_M_MAX, mm);
    write_reg(gts_pkg::CFG_M_HALF, mh);
    write_reg(gts_pkg::CFG_DECAY, dc);
    write_reg(gts_pkg::CFG_COUPLED, cp);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || offering || expected_steps.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic gts_pkg::in_word_t random_word();
    gts_pkg::in_word_t w;
    int sel;
    sel = $urandom_range(0, 99);
    w.rand_time = $urandom;
    w.rand_pick = $urandom;
    if (sel < 2) w.rand_time = 0;
    else if (sel < 4) w.rand_pick = 0;
    else if (sel < 10) w.rand_time = $urandom_range(1, 255);
    else if (sel < 14) w.rand_time = 32'hFFFF_FFFF - $urandom_range(0, 255);
    return w;
  endfunction

  function automatic logic [47:0] random_rate();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0] >> $urandom_range(0, 47);
  endfunction

  function automatic logic [47:0] random_half();
    return ($urandom_range(0, 9) == 0) ? 48'd0 : 48'($urandom_range(0, 65535));
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) pending_words.push_back(random_word());
  endtask

  task automatic send_pair(logic [31:0] t, logic [31:0] p);
    gts_pkg::in_word_t w;
    w.rand_time = t;
    w.rand_pick = p;
    pending_words.push_back(w);
  endtask

  initial begin
    k_basal = 64'(gts_pkg::K_BASAL_RESET);
    k_max = 64'(gts_pkg::K_MAX_RESET);
    k_half = 64'(gts_pkg::K_HALF_RESET);
    m_basal = 64'(gts_pkg::M_BASAL_RESET);
    m_max = 64'(gts_pkg::M_MAX_RESET);
    m_half = 64'(gts_pkg::M_HALF_RESET);
    decay = 64'(gts_pkg::DECAY_RESET);
    coupled = 64'(gts_pkg::COUPLED_RESET);
    count_k = 64'(gts_pkg::COUNT_K_RESET);
    count_m = 64'(gts_pkg::COUNT_M_RESET);
    sim_clock = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: zero fractions, extremes, each reaction
    send_pair(32'd0, 32'h1234_5678);
    send_pair(32'h1234_5678, 32'd0);
    send_pair(32'd0, 32'd0);
    send_pair(32'd1, 32'd1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'd1, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'd1);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h0000_0002, 32'h4000_0000);
    send_pair(32'h5555_5555, 32'hC000_0000);
    send_pair(32'hAAAA_AAAA, 32'hF000_0000);
    wait_drained();

    // default kinetics
    send_random(400);
    wait_drained();

    // all rates at the top, propensities saturate
    write_all(ALL_ONES48, ALL_ONES48, 48'd65535, ALL_ONES48, ALL_ONES48, 48'd65535,
              ALL_ONES48, ALL_ONES48);
    write_reg(CFG_SPARE, ALL_ONES48);
    send_random(100);
    wait_drained();

    // zero half points
    write_all(48'd0, 48'h0001_0000_0000, 48'd0, 48'h0000_1000_0000, 48'h0002_0000_0000,
              48'd0, 48'h0000_1000_0000, 48'h0000_0010_0000);
    send_random(100);
    wait_drained();

    // dead system: nothing can happen
    write_all(48'd0, 48'd0, 48'd1, 48'd0, 48'd0, 48'd1, 48'd0, 48'd0);
    send_random(20);
    wait_drained();

    // decay only, K and M run down to zero
    write_all(48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'h1000_0000_0000, 48'd0);
    send_random(700);
    wait_drained();

    // random kinetics
    for (int c = 0; c < 6; c++) begin
      write_all(random_rate(), random_rate(), random_half(), random_rate(), random_rate(),
                random_half(), random_rate(), random_rate());
      send_random(100);
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
